// ----- rtl/sdr_pkg.sv -----
// Shared types, widths and codes for the slot allocator with deferred release.
package sdr_pkg;

  localparam int MAX_SLOTS_DEF     = 64;
  localparam int PENDING_DEPTH_DEF = 64;
  localparam int MAX_RESULTS       = 64;
  localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam int SLOT_W     = 6;
  localparam int VIEW_W     = 64;
  localparam int FRAME_W    = 64;
  localparam int CAP_W      = 7;
  localparam int FIF_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int S_TDATA_W = 136;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 80;
  localparam int M_TUSER_W = 4;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_RETIRE  = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED  = 2'd0,
    CFG_CAPACITY = 2'd1,
    CFG_FIF      = 2'd2,
    CFG_WHITE    = 2'd3
  } cfg_idx_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QOVF     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SOVF     = 3'd5;

  typedef struct packed {
    logic latch;
    logic exec_single;
    logic pop;
    logic emit_held;
    logic emit_last;
    logic emit_null;
  } sdr_cmd_t;

  typedef struct packed {
    logic ret_ok;
    logic held_valid;
    logic out_free;
  } sdr_stat_t;

endpackage

// ----- rtl/sdr_ctrl.sv -----
// Controller state machine: sequences acquire, release, retire and unused requests.
module sdr_ctrl
  import sdr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 s_tready,
  input  sdr_stat_t            stat,
  output sdr_cmd_t             cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    RET_CHK,
    RET_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.latch  = 1'b1;
          state_next = (req_t'(s_tuser) == REQ_RETIRE) ? RET_CHK : EXEC;
        end
      end
      EXEC: begin
        if (stat.out_free) begin
          cmd.exec_single = 1'b1;
          state_next      = IDLE;
        end
      end
      RET_CHK: begin
        if (!stat.held_valid) begin
          if (stat.ret_ok) begin
            cmd.pop    = 1'b1;
            state_next = RET_WAIT;
          end else if (stat.out_free) begin
            cmd.emit_null = 1'b1;
            state_next    = IDLE;
          end
        end else if (stat.out_free) begin
          cmd.emit_held = 1'b1;
          if (stat.ret_ok) begin
            cmd.pop    = 1'b1;
            state_next = RET_WAIT;
          end else begin
            cmd.emit_last = 1'b1;
            state_next    = IDLE;
          end
        end
      end
      RET_WAIT: begin
        state_next = RET_CHK;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == IDLE);
    end
  end

endmodule

// ----- rtl/sdr_dpath.sv -----
// Datapath: config registers, free stack, pending queue, counters and result register.
module sdr_dpath
  import sdr_pkg::*;
#(
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  sdr_cmd_t              cmd,
  output sdr_stat_t             stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [M_TUSER_W-1:0]  m_tuser,
  output logic                  m_tlast
);

  localparam int SA_W = $clog2(MAX_SLOTS);
  localparam int SC_W = $clog2(MAX_SLOTS + 1);
  localparam int PA_W = $clog2(PENDING_DEPTH);
  localparam int PC_W = $clog2(PENDING_DEPTH + 1);
  localparam int CW   = (SC_W > CAP_W) ? SC_W : CAP_W;

  // configuration
  logic              enabled;
  logic [CAP_W-1:0]  capacity;
  logic [FIF_W-1:0]  fif;
  logic [VIEW_W-1:0] white_view;

  // latched request
  req_t               req_q;
  logic [VIEW_W-1:0]  view_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FRAME_W-1:0] frame_q;

  // free stack
  logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
  logic [SLOT_W-1:0] stack_rd;
  logic [SC_W-1:0]   free_count;
  logic [SC_W-1:0]   free_dec;
  logic [SA_W-1:0]   stack_rd_addr;
  logic [CW-1:0]     next_fresh;

  // pending queue
  logic [SLOT_W-1:0]  pend_slot_mem  [PENDING_DEPTH];
  logic [FRAME_W-1:0] pend_frame_mem [PENDING_DEPTH];
  logic [SLOT_W-1:0]  pend_rd_slot;
  logic [FRAME_W-1:0] pend_rd_frame;
  logic [PA_W-1:0]    head;
  logic [PA_W-1:0]    tail;
  logic [PC_W-1:0]    pend_count;

  // retire walk
  logic [RES_CNT_W-1:0] ret_n;
  logic [SLOT_W-1:0]    held_slot;
  logic                 held_sovf;

  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      cap_eff;
  logic               stack_full;
  logic               pend_full;
  logic               acq_dis;
  logic               acq_pop;
  logic               acq_fresh;
  logic               rel_ok;
  logic               enqueue;
  logic               push;
  logic [FRAME_W:0]   due;
  logic               frame_ok;
  logic               load;

  logic [SLOT_W-1:0]   res_granted;
  logic                res_wv;
  logic [SLOT_W-1:0]   res_wslot;
  logic [VIEW_W-1:0]   res_wview;
  logic [STATUS_W-1:0] res_status;

  logic [SLOT_W-1:0]   o_granted;
  logic                o_wv;
  logic [SLOT_W-1:0]   o_wslot;
  logic [VIEW_W-1:0]   o_wview;
  logic [STATUS_W-1:0] o_status;
  logic                o_last;

  assign cap_ext       = CW'(capacity);
  assign cap_eff       = (cap_ext < CW'(MAX_SLOTS)) ? cap_ext : CW'(MAX_SLOTS);
  assign stack_full    = (free_count == SC_W'(MAX_SLOTS));
  assign pend_full     = (pend_count == PC_W'(PENDING_DEPTH));
  assign free_dec      = free_count - SC_W'(1);
  assign stack_rd_addr = free_dec[SA_W-1:0];

  assign acq_dis   = !enabled || (view_q == '0);
  assign acq_pop   = (free_count != '0);
  assign acq_fresh = (next_fresh < cap_eff);
  assign rel_ok    = (slot_q != '0) && (CW'(slot_q) < cap_eff);
  assign enqueue   = cmd.exec_single && (req_q == REQ_RELEASE) && rel_ok && !pend_full;
  assign push      = cmd.pop && !stack_full;

  // exact compare, no wrap at 64 bits
  assign due      = {1'b0, pend_rd_frame} + {{(FRAME_W + 1 - FIF_W){1'b0}}, fif};
  assign frame_ok = ({1'b0, frame_q} >= due);

  assign stat.ret_ok     = (pend_count != '0) && (ret_n < RES_CNT_W'(MAX_RESULTS)) && frame_ok;
  assign stat.held_valid = (ret_n != '0);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      capacity   <= CAP_W'(64);
      fif        <= FIF_W'(2);
      white_view <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ENABLED:  enabled    <= cfg_data[0];
        CFG_CAPACITY: capacity   <= cfg_data[CAP_W-1:0];
        CFG_FIF:      fif        <= cfg_data[FIF_W-1:0];
        CFG_WHITE:    white_view <= cfg_data[VIEW_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q   <= req_t'(s_tuser);
      view_q  <= s_tdata[63:0];
      slot_q  <= s_tdata[69:64];
      frame_q <= s_tdata[133:70];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[free_count[SA_W-1:0]] <= pend_rd_slot;
    end
    stack_rd <= stack_mem[stack_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (enqueue) begin
      pend_slot_mem[tail]  <= slot_q;
      pend_frame_mem[tail] <= frame_q;
    end
    pend_rd_slot  <= pend_slot_mem[head];
    pend_rd_frame <= pend_frame_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      next_fresh <= CW'(1);
      head       <= '0;
      tail       <= '0;
      pend_count <= '0;
      ret_n      <= '0;
    end else begin
      if (cmd.exec_single && req_q == REQ_ACQUIRE && !acq_dis) begin
        if (acq_pop) begin
          free_count <= free_dec;
        end else if (acq_fresh) begin
          next_fresh <= next_fresh + CW'(1);
        end
      end
      if (enqueue) begin
        tail       <= (tail == PA_W'(PENDING_DEPTH - 1)) ? '0 : tail + PA_W'(1);
        pend_count <= pend_count + PC_W'(1);
      end
      if (cmd.latch) begin
        ret_n <= '0;
      end else if (cmd.pop) begin
        ret_n <= ret_n + RES_CNT_W'(1);
      end
      if (cmd.pop) begin
        head       <= (head == PA_W'(PENDING_DEPTH - 1)) ? '0 : head + PA_W'(1);
        pend_count <= pend_count - PC_W'(1);
      end
      if (push) begin
        free_count <= free_count + SC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      held_slot <= pend_rd_slot;
      held_sovf <= stack_full;
    end
  end

  always_comb begin
    res_granted = '0;
    res_wv      = 1'b0;
    res_wslot   = '0;
    res_wview   = '0;
    res_status  = ST_OK;
    unique case (req_q)
      REQ_ACQUIRE: begin
        if (acq_dis) begin
          res_status = ST_DISABLED;
        end else if (acq_pop || acq_fresh) begin
          res_granted = acq_pop ? stack_rd : next_fresh[SLOT_W-1:0];
          res_wv      = 1'b1;
          res_wslot   = res_granted;
          res_wview   = view_q;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_RELEASE: begin
        if (!rel_ok) begin
          res_status = ST_IGNORED;
        end else if (pend_full) begin
          res_status = ST_QOVF;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign load = cmd.exec_single || cmd.emit_held || cmd.emit_null;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_single) begin
      o_granted <= res_granted;
      o_wv      <= res_wv;
      o_wslot   <= res_wslot;
      o_wview   <= res_wview;
      o_status  <= res_status;
      o_last    <= 1'b1;
    end else if (cmd.emit_held) begin
      o_granted <= '0;
      o_wv      <= 1'b1;
      o_wslot   <= held_slot;
      o_wview   <= white_view;
      o_status  <= held_sovf ? ST_SOVF : ST_OK;
      o_last    <= cmd.emit_last;
    end else if (cmd.emit_null) begin
      o_granted <= '0;
      o_wv      <= 1'b0;
      o_wslot   <= '0;
      o_wview   <= '0;
      o_status  <= ST_OK;
      o_last    <= 1'b1;
    end
  end

  assign m_tdata = {4'b0000, o_wview, o_wslot, o_granted};
  assign m_tuser = {o_status, o_wv};
  assign m_tlast = o_last;

endmodule

// ----- rtl/slot_allocator_deferred_release_unit.sv -----
// Acquire, release and unused requests are latched on the transfer, run in the EXEC step once the
// output register is free, and their result is registered there; no new request is taken before that step.
// Retire: each popped queue entry passes through RET_CHK and RET_WAIT as it is read from the
// queue memory and checked; the run closes in RET_CHK; results wait in one output register.
// Reset: counters and pointers cleared, config to defaults; stack and queue memories
// are not cleared and need no clearing pass.
module slot_allocator_deferred_release_unit
  import sdr_pkg::*;
#(
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // view_handle, slot_index, frame_number, pad
  input  logic [S_TUSER_W-1:0]  s_tuser,  // req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // granted_slot, write_slot, write_view, pad
  output logic [M_TUSER_W-1:0]  m_tuser,  // write_valid, status
  output logic                  m_tlast   // last
);

  sdr_cmd_t  cmd;
  sdr_stat_t stat;

  assign cfg_ready = 1'b1;

  sdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdr_dpath #(
    .MAX_SLOTS     (MAX_SLOTS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/sdr_checker.sv -----
// Port-level checks on the result stream, bound to the top level.
module sdr_checker
  import sdr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser,
  input logic                 m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("slot or view set without table write");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[3:1] == ST_DISABLED || m_tuser[3:1] == ST_FULL ||
                 m_tuser[3:1] == ST_IGNORED || m_tuser[3:1] == ST_QOVF)
    |-> !m_tuser[0] && m_tlast)
    else $error("error result carries a write or is not last");

  a_sovf_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:1] == ST_SOVF |-> m_tuser[0] && m_tdata[5:0] == '0)
    else $error("stack overflow result without white write");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:1] <= ST_SOVF)
    else $error("status code out of range");

endmodule

bind slot_allocator_deferred_release_unit sdr_checker u_sdr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- test/slot_allocator_deferred_release_unit_tb.sv -----
// Self-checking testbench for the slot allocator with deferred release, streaming ports.
`timescale 1ns / 1ps

module slot_allocator_deferred_release_unit_tb;
  import sdr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [63:0] FRAME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    req_t        kind;
    logic [63:0] view;
    logic [5:0]  slot;
    logic [63:0] frame;
  } slot_request_t;

  typedef struct packed {
    logic [5:0]  granted;
    logic        wr_valid;
    logic [5:0]  wr_slot;
    logic [63:0] wr_view;
    logic [2:0]  status;
    logic        last;
  } slot_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // view_handle, slot_index, frame_number, pad
  logic [S_TUSER_W-1:0] s_tuser = '0;  // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // granted_slot, write_slot, write_view, pad
  logic [M_TUSER_W-1:0] m_tuser;       // write_valid, status
  logic m_tlast;

  slot_allocator_deferred_release_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // allocator state as the testbench sees it
  logic             mdl_en = 1'b0;
  logic [6:0]       mdl_cap = 7'd64;
  logic [3:0]       mdl_fif = 4'd2;
  logic [63:0]      mdl_white = '0;
  logic [5:0]       free_slots [MAX_SLOTS_DEF];
  int               free_cnt = 0;
  int               fresh_slot = 1;
  logic [5:0]       held_slot [PENDING_DEPTH_DEF];
  logic [63:0]      held_frame [PENDING_DEPTH_DEF];
  int               held_head = 0;
  int               held_tail = 0;
  int               held_cnt = 0;

  slot_request_t    request_backlog [$];
  slot_result_t     due_results [$];
  slot_request_t    cur_req;
  logic [63:0]      gen_frame = 64'd1000;
  int               src_idle_pct = 0;
  int               sink_stall_pct = 0;
  int               errors = 0;
  int               n_in = 0;
  int               n_out = 0;
  int               status_seen [8];
  int               cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int cap_eff();
    return (mdl_cap < MAX_SLOTS_DEF) ? int'(mdl_cap) : MAX_SLOTS_DEF;
  endfunction

  // expected results of one accepted request; updates the tracked state
  task automatic advance_allocator(input slot_request_t it);
    slot_result_t r;
    slot_result_t held;
    bit have_held;
    bit granted;
    int n;
    logic [5:0] s;
    logic [63:0] pf;
    r = '0;
    r.last = 1'b1;
    have_held = 0;
    granted = 0;
    n = 0;
    s = '0;
    case (it.kind)
      REQ_ACQUIRE: begin
        if (!mdl_en || it.view == '0) begin
          r.status = ST_DISABLED;
        end else if (free_cnt > 0) begin
          free_cnt--;
          s = free_slots[free_cnt];
          granted = 1;
        end else if (fresh_slot < cap_eff()) begin
          s = fresh_slot[5:0];
          fresh_slot++;
          granted = 1;
        end else begin
          r.status = ST_FULL;
        end
        if (granted) begin
          r.granted = s;
          r.wr_valid = 1'b1;
          r.wr_slot = s;
          r.wr_view = it.view;
          r.status = ST_OK;
        end
        due_results.insert(due_results.size(), r);
      end
      REQ_RELEASE: begin
        if (it.slot == '0 || int'(it.slot) >= cap_eff()) begin
          r.status = ST_IGNORED;
        end else if (held_cnt >= PENDING_DEPTH_DEF) begin
          r.status = ST_QOVF;
        end else begin
          held_slot[held_tail] = it.slot;
          held_frame[held_tail] = it.frame;
          held_tail = (held_tail + 1) % PENDING_DEPTH_DEF;
          held_cnt++;
        end
        due_results.insert(due_results.size(), r);
      end
      REQ_RETIRE: begin
        while (n < MAX_RESULTS && held_cnt > 0) begin
          pf = held_frame[held_head];
          if (!(it.frame >= pf && it.frame - pf >= {60'd0, mdl_fif})) break;
          s = held_slot[held_head];
          held_head = (held_head + 1) % PENDING_DEPTH_DEF;
          held_cnt--;
          if (have_held) due_results.insert(due_results.size(), held);
          held = '0;
          held.wr_valid = 1'b1;
          held.wr_slot = s;
          held.wr_view = mdl_white;
          if (free_cnt >= MAX_SLOTS_DEF) begin
            held.status = ST_SOVF;
          end else begin
            free_slots[free_cnt] = s;
            free_cnt++;
            held.status = ST_OK;
          end
          have_held = 1;
          n++;
        end
        if (have_held) begin
          held.last = 1'b1;
          due_results.insert(due_results.size(), held);
        end else begin
          due_results.insert(due_results.size(), r);
        end
      end
      default: begin
        due_results.insert(due_results.size(), r);
      end
    endcase
  endtask

  // request source
  always @(posedge clk) begin
    slot_request_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_allocator(cur_req);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = request_backlog[0];
          request_backlog.delete(0);
          cur_req = nxt;
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, nxt.frame, nxt.slot, nxt.view};
          s_tuser <= nxt.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      errors++;
    end
  endfunction

  // result sink and checker
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        status_seen[m_tuser[3:1]]++;
        if (due_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          check_field("granted_slot", 64'(want.granted), 64'(m_tdata[5:0]));
          check_field("write_valid", 64'(want.wr_valid), 64'(m_tuser[0]));
          check_field("write_slot", 64'(want.wr_slot), 64'(m_tdata[11:6]));
          check_field("write_view", want.wr_view, m_tdata[75:12]);
          check_field("status", 64'(want.status), 64'(m_tuser[3:1]));
          check_field("last", 64'(want.last), 64'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic add_req(input req_t k, input logic [63:0] view, input logic [5:0] slot,
                         input logic [63:0] frame);
    slot_request_t it;
    it.kind = k;
    it.view = view;
    it.slot = slot;
    it.frame = frame;
    request_backlog.insert(request_backlog.size(), it);
  endtask

  // entered and left on a rising edge
  task automatic set_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLED:  mdl_en = val[0];
      CFG_CAPACITY: mdl_cap = val[6:0];
      CFG_FIF:      mdl_fif = val[3:0];
      default:      mdl_white = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic en, input logic [6:0] cap, input logic [3:0] fif,
                               input logic [63:0] white);
    set_reg(CFG_ENABLED, {63'd0, en});
    set_reg(CFG_CAPACITY, {57'd0, cap});
    set_reg(CFG_FIF, {60'd0, fif});
    set_reg(CFG_WHITE, white);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (request_backlog.size() != 0 || s_tvalid || due_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // mostly acquire/release/retire traffic around a running frame count, some noise
  task automatic queue_random_requests(input int count);
    slot_request_t it;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      it.kind = REQ_ACQUIRE;
      it.view = {$urandom, $urandom};
      it.slot = '0;
      it.frame = gen_frame;
      if (roll < 38) begin
        if ($urandom_range(29) == 0) it.view = '0;
      end else if (roll < 68) begin
        it.kind = REQ_RELEASE;
        it.slot = 6'($urandom_range(cap_eff() - 1, 1));
        it.frame = gen_frame - 64'($urandom_range(2));
      end else if (roll < 86) begin
        it.kind = REQ_RETIRE;
      end else begin
        it.kind = req_t'($urandom_range(3));
        it.slot = 6'($urandom_range(63));
        it.frame = (it.kind == REQ_RETIRE) ? {$urandom, $urandom}
                                           : gen_frame + 64'($urandom_range(40));
      end
      request_backlog.insert(request_backlog.size(), it);
      if ($urandom_range(2) == 0) gen_frame = gen_frame + 64'($urandom_range(3, 1));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled table: fallback grant, releases still queued, frame-gated retires
    apply_setting(1'b0, 7'd64, 4'd2, {$urandom, $urandom});
    add_req(REQ_ACQUIRE, {$urandom, $urandom} | 64'd1, 6'd0, 64'd0);
    add_req(REQ_RELEASE, 64'd0, 6'd5, 64'd0);
    add_req(REQ_RELEASE, 64'd0, 6'd0, 64'd7);
    add_req(REQ_RELEASE, 64'd0, 6'd63, 64'd100);
    add_req(REQ_UNUSED, FRAME_MAX, 6'd63, FRAME_MAX);
    add_req(REQ_RETIRE, 64'd0, 6'd0, 64'd1);
    add_req(REQ_RETIRE, 64'd0, 6'd0, 64'd2);
    add_req(REQ_RETIRE, 64'd0, 6'd0, 64'd102);
    wait_idle();

    // null view, reuse from the free stack, fresh slot, retire at the top frame
    apply_setting(1'b1, 7'd64, 4'd0, FRAME_MAX);
    add_req(REQ_ACQUIRE, 64'd0, 6'd0, 64'd0);
    add_req(REQ_ACQUIRE, FRAME_MAX, 6'd0, 64'd0);
    add_req(REQ_ACQUIRE, 64'h5555_AAAA_5555_AAAA, 6'd0, 64'd0);
    add_req(REQ_ACQUIRE, 64'hAAAA_5555_AAAA_5555, 6'd0, 64'd0);
    add_req(REQ_RELEASE, 64'd0, 6'd1, FRAME_MAX);
    add_req(REQ_RELEASE, 64'd0, 6'd63, 64'd5);
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    wait_idle();

    // capacity 2: stacked slot above capacity, full table, no wrap in the frame test
    apply_setting(1'b1, 7'd2, 4'd15, 64'd0);
    add_req(REQ_ACQUIRE, 64'd1, 6'd0, 64'd0);
    add_req(REQ_ACQUIRE, 64'd2, 6'd0, 64'd0);
    add_req(REQ_ACQUIRE, 64'd3, 6'd0, 64'd0);
    add_req(REQ_RELEASE, 64'd0, 6'd1, FRAME_MAX - 64'd3);
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    add_req(REQ_RELEASE, 64'd0, 6'd63, 64'd0);
    wait_idle();

    apply_setting(1'b1, 7'd64, 4'd2, {$urandom, $urandom});
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    queue_random_requests(40);
    wait_idle();

    src_idle_pct = 48;
    apply_setting(1'b1, 7'd9, 4'd0, 64'd0);
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    queue_random_requests(40);
    wait_idle();

    src_idle_pct = 0;
    sink_stall_pct = 48;
    apply_setting(1'b1, 7'd2, 4'd15, FRAME_MAX);
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    queue_random_requests(40);
    wait_idle();

    src_idle_pct = 22;
    sink_stall_pct = 22;
    gen_frame = 64'h8000_0000_0000_0000;
    apply_setting(1'b1, 7'd40, 4'd7, {$urandom, $urandom});
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    queue_random_requests(40);
    wait_idle();

    // fill the queue past depth, then overfill the free stack
    apply_setting(1'b1, 7'd64, 4'd0, {$urandom, $urandom});
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    for (int i = 0; i < PENDING_DEPTH_DEF + 1; i++)
      add_req(REQ_RELEASE, 64'd0, 6'($urandom_range(63, 1)), {$urandom, $urandom});
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    add_req(REQ_RELEASE, 64'd0, 6'd1, 64'd0);
    add_req(REQ_RETIRE, 64'd0, 6'd0, FRAME_MAX);
    for (int i = 0; i < 20; i++)
      add_req(REQ_ACQUIRE, {$urandom, $urandom}, 6'd0, 64'd0);
    wait_idle();

    $display("%0d requests and %0d results checked over reset, directed and four random settings",
             n_in, n_out);
    $display("status mix: ok %0d, fallback %0d, full %0d, ignored %0d, queue ovf %0d, stack ovf %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
